// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the line stepper RTL.
// No dependencies; every assertion is clocked on clk_i and held off during rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: the antecedent leads to the consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/bls_pkg.sv =====
// Shared types and codes for the Bresenham line stepper.
// No dependencies; used by bls_ctrl and bresenham_line_stepper.
package bls_pkg;

  // Command codes carried in tuser of the input beat.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SPAN  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_DONE  = 5'b10000
  } bls_state_e;

  typedef struct packed {
    logic accept;
    logic span_en;
    logic setup_en;
    logic step_en;
    logic result_en;
  } bls_ctl_t;

endpackage

// ===== rtl/core/bls_step_unit.sv =====
// One Bresenham step: next position and next error term from the current ones.
// No dependencies; shared by every point of a walk under the sequencer.
module bls_step_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH:0]   cur_x_i,
  input  logic signed [COORD_WIDTH:0]   cur_y_i,
  input  logic signed [COORD_WIDTH+2:0] err_i,
  input  logic signed [COORD_WIDTH+2:0] inc_straight_i,
  input  logic signed [COORD_WIDTH+2:0] inc_diagonal_i,
  input  logic                          dir_x_neg_i,
  input  logic                          dir_y_neg_i,
  input  logic                          x_major_i,
  output logic signed [COORD_WIDTH:0]   next_x_o,
  output logic signed [COORD_WIDTH:0]   next_y_o,
  output logic signed [COORD_WIDTH+2:0] next_err_o
);

  logic                        diag;
  logic                        move_x;
  logic                        move_y;
  logic signed [COORD_WIDTH:0] delta_x;
  logic signed [COORD_WIDTH:0] delta_y;

  // A non-negative error term calls for a step on the minor axis as well.
  assign diag    = ~err_i[COORD_WIDTH+2];
  assign move_x  = x_major_i | diag;
  assign move_y  = ~x_major_i | diag;
  assign delta_x = dir_x_neg_i ? '1 : (COORD_WIDTH+1)'(1);
  assign delta_y = dir_y_neg_i ? '1 : (COORD_WIDTH+1)'(1);

  assign next_x_o   = move_x ? cur_x_i + delta_x : cur_x_i;
  assign next_y_o   = move_y ? cur_y_i + delta_y : cur_y_i;
  assign next_err_o = err_i + (diag ? inc_diagonal_i : inc_straight_i);

endmodule

// ===== rtl/core/bls_ctrl.sv =====
// Sequencer: accept, span and setup (start) or walk (advance), result hand-off.
// Depends on bls_pkg for the state encoding and the control struct.
module bls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               cmd_i,
  input  logic               can_step_i,
  input  logic               out_free_i,
  output logic               ready_o,
  output bls_pkg::bls_ctl_t  ctl_o
);
  import bls_pkg::*;

  bls_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d = (cmd_i == CMD_ADVANCE) ? ST_WALK : ST_SPAN;
        end
      end
      ST_SPAN: begin
        ctl_o.span_en = 1'b1;
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        ctl_o.setup_en = 1'b1;
        state_d = ST_DONE;
      end
      ST_WALK: begin
        if (can_step_i) begin
          ctl_o.step_en = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctl_o.result_en = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/bresenham_line_stepper.sv =====
// Channel  | Dir | tdata (low bit up)                          | tuser (low bit up)
// s_axis   | in  | start_x, start_y, end_x, end_y, steps, pad  | cmd
// m_axis   | out | point_x, point_y, pad                       | complete, more_left
//
// A start beat passes through the span and setup states, then loads the output register. An
// advance of up to N points takes a step of the shared step unit per point, then sees that the
// walk is over and loads the output register. The input is ready again in the cycle after that.
// A new beat is taken while an earlier result still waits, but its own result then stalls.
// Reset leaves the block idle with no line loaded and the last point at the origin.
// Top level of the Bresenham line stepper; depends on bls_pkg, bls_ctrl, bls_step_unit
// and assert_macros.svh.
`include "assert_macros.svh"

module bresenham_line_stepper #(
  parameter int COORD_WIDTH = 16,
  parameter int STEP_WIDTH  = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // start_x, start_y, end_x, end_y, steps, zero padding
  input  logic [((4*COORD_WIDTH+STEP_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  logic [0:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // point_x, point_y, zero padding
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // complete, more_left
  output logic [1:0] m_axis_tuser_o
);
  import bls_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int EW       = COORD_WIDTH + 3;
  localparam int OUT_DATA = ((2*COORD_WIDTH+7)/8)*8;

  bls_ctl_t ctl;

  logic signed [CW-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic [STEP_WIDTH-1:0] in_steps;

  logic signed [CW:0]   cur_x_q, cur_y_q;
  logic signed [CW-1:0] end_x_q, end_y_q;
  logic [CW-1:0]        span_x_q, span_y_q;
  logic                 dir_x_neg_q, dir_y_neg_q, x_major_q;
  logic [CW-1:0]        major_q;
  logic signed [EW-1:0] err_q, inc_str_q, inc_diag_q;
  logic [CW:0]          idx_q;
  logic [STEP_WIDTH-1:0] rem_q;
  logic [CW-1:0]        last_x_q, last_y_q;
  logic                 out_valid_q;
  logic [OUT_DATA-1:0]  out_data_q;
  logic [1:0]           out_user_q;

  logic signed [CW:0]   diff_x, diff_y, abs_x, abs_y;
  logic                 setup_x_major;
  logic [CW-1:0]        lo, hi;
  logic signed [CW:0]   lo_minus_hi;
  logic signed [EW-1:0] setup_inc_str;
  logic signed [CW:0]   next_x, next_y;
  logic signed [EW-1:0] next_err;
  logic                 more_left, can_step, out_free;

  assign in_start_x = s_axis_tdata_i[CW-1:0];
  assign in_start_y = s_axis_tdata_i[2*CW-1:CW];
  assign in_end_x   = s_axis_tdata_i[3*CW-1:2*CW];
  assign in_end_y   = s_axis_tdata_i[4*CW-1:3*CW];
  assign in_steps   = s_axis_tdata_i[4*CW +: STEP_WIDTH];

  assign more_left = (idx_q <= {1'b0, major_q});
  assign can_step  = (rem_q != '0) && more_left;
  assign out_free  = ~out_valid_q | m_axis_tready_i;

  bls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .cmd_i      (s_axis_tuser_i[0]),
    .can_step_i (can_step),
    .out_free_i (out_free),
    .ready_o    (s_axis_tready_o),
    .ctl_o      (ctl)
  );

  bls_step_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_step (
    .cur_x_i        (cur_x_q),
    .cur_y_i        (cur_y_q),
    .err_i          (err_q),
    .inc_straight_i (inc_str_q),
    .inc_diagonal_i (inc_diag_q),
    .dir_x_neg_i    (dir_x_neg_q),
    .dir_y_neg_i    (dir_y_neg_q),
    .x_major_i      (x_major_q),
    .next_x_o       (next_x),
    .next_y_o       (next_y),
    .next_err_o     (next_err)
  );

  // Span state: signed distances, directions and absolute spans.
  assign diff_x = {end_x_q[CW-1], end_x_q} - cur_x_q;
  assign diff_y = {end_y_q[CW-1], end_y_q} - cur_y_q;
  assign abs_x  = diff_x[CW] ? -diff_x : diff_x;
  assign abs_y  = diff_y[CW] ? -diff_y : diff_y;

  // Setup state: major axis, increments and the initial error term.
  assign setup_x_major = (span_x_q > span_y_q);
  assign lo            = setup_x_major ? span_y_q : span_x_q;
  assign hi            = setup_x_major ? span_x_q : span_y_q;
  assign lo_minus_hi   = $signed({1'b0, lo}) - $signed({1'b0, hi});
  assign setup_inc_str = $signed({2'b00, lo, 1'b0});

  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      // Only a start beat carries endpoints; an advance carries on from the current point.
      if (s_axis_tuser_i[0] == CMD_START) begin
        cur_x_q <= {in_start_x[CW-1], in_start_x};
        cur_y_q <= {in_start_y[CW-1], in_start_y};
        end_x_q <= in_end_x;
        end_y_q <= in_end_y;
      end
      // A start beat asks for no points, so it always reports complete.
      rem_q   <= (s_axis_tuser_i[0] == CMD_ADVANCE) ? in_steps : '0;
    end
    if (ctl.span_en) begin
      span_x_q    <= abs_x[CW-1:0];
      span_y_q    <= abs_y[CW-1:0];
      dir_x_neg_q <= diff_x[CW] | (diff_x == '0);
      dir_y_neg_q <= diff_y[CW] | (diff_y == '0);
    end
    if (ctl.setup_en) begin
      x_major_q  <= setup_x_major;
      inc_str_q  <= setup_inc_str;
      inc_diag_q <= {lo_minus_hi[CW], lo_minus_hi, 1'b0};
      err_q      <= setup_inc_str - $signed({3'b000, hi});
    end
    if (ctl.step_en) begin
      cur_x_q <= next_x;
      cur_y_q <= next_y;
      err_q   <= next_err;
      rem_q   <= rem_q - 1'b1;
    end
    if (ctl.result_en) begin
      out_data_q <= OUT_DATA'({last_y_q, last_x_q});
      out_user_q <= {more_left, (rem_q == '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= (CW+1)'(1);
      major_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl.setup_en) begin
        idx_q   <= '0;
        major_q <= hi;
      end else if (ctl.step_en) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctl.step_en) begin
        last_x_q <= cur_x_q[CW-1:0];
        last_y_q <= cur_y_q[CW-1:0];
      end
      out_valid_q <= ctl.result_en | (out_valid_q & ~m_axis_tready_i);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `ASSERT_IMPL(a_result_into_free_slot, ctl.result_en, !out_valid_q || m_axis_tready_i, "result overwrote a pending beat")
  `ASSERT_CLK(a_index_bounded, idx_q <= ({1'b0, major_q} + 1'b1), "point index ran past the line end")
  `ASSERT_CLK(a_step_counts_down, ctl.step_en |=> rem_q == $past(rem_q) - 1'b1, "step count not consumed")

endmodule
